@@ hw/rtl/qpht_pkg.sv @@
// Shared types and constants of the quadratic-probe hash table.
package qpht_pkg;

  // Width and reset value of the table size register.
  localparam int unsigned SIZE_REG_W = 11;
  localparam logic [SIZE_REG_W-1:0] SIZE_REG_RESET = 11'd1024;

  // Output field widths and the padded result bus.
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W = 10;
  localparam int unsigned OUT_TDATA_W = 16;

  // Request op codes as they arrive on the input bus.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;

  // Decoded command handed from the front end to the probe engine.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FOUND     = 3'd4
  } status_e;

endpackage

@@ hw/rtl/quadratic_probe_hash_table_core.sv @@
// Top level of the quadratic-probe hash table core.
//
// Requests arrive on the s_axis channel (op and key) and each one yields
// exactly one result on the m_axis channel (status and slot). The table
// size register is written through the cfg channel; the user must write
// it only while idle, since the block does not enforce this. After reset
// the slot memory is swept clear, one slot a cycle; s_axis_tready_o stays
// low until the sweep is done, while cfg_ready_o is held high throughout.
// The front end reduces the key modulo the table size one bit a cycle, so
// it holds a request through the whole division before passing it to a
// two-entry queue, and takes no new request until then. The probe engine
// handles each probe as a memory read, then a check; it pops a request
// only while the output register is empty, and a long chain can probe
// every slot of the table. Sustained throughput is set by the serial
// modulo unit, or by the probe engine when chains grow long. A result
// sits in an output register; while the receiver stalls, the front end
// keeps accepting and the queue fills, then s_axis_tready_o drops.
module quadratic_probe_hash_table_core #(
  parameter int unsigned DEPTH    = 1024,
  parameter int unsigned KEY_BITS = 31
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // Fields from bit 0: op (2), key (KEY_BITS), zero padding.
  input  logic [((KEY_BITS + 9) / 8) * 8 - 1:0] s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // Fields from bit 0: status (3), slot (10), zero padding.
  output logic [qpht_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [qpht_pkg::SIZE_REG_W-1:0]      cfg_data_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned SW = $clog2(DEPTH + 1);
  localparam int unsigned QW = 2 + KEY_BITS + AW;

  logic [qpht_pkg::SIZE_REG_W-1:0] size_reg_q;
  logic [SW-1:0] size_act;
  logic init_done;

  logic f_valid, f_ready, q_valid, q_ready;
  qpht_pkg::cmd_e f_cmd, q_cmd;
  logic [KEY_BITS-1:0] f_key, q_key;
  logic [AW-1:0] f_home, q_home;
  logic [QW-1:0] q_data;
  qpht_pkg::status_e r_status;
  logic [qpht_pkg::SLOT_W-1:0] r_slot;

  // Table size register, written by a cfg transfer.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_reg_q <= qpht_pkg::SIZE_REG_RESET;
    end else if (cfg_valid_i) begin
      size_reg_q <= cfg_data_i;
    end
  end

  // Clamp the register to the range 1..DEPTH.
  always_comb begin
    if (size_reg_q == '0) begin
      size_act = SW'(1);
    end else if (32'(size_reg_q) > 32'(DEPTH)) begin
      size_act = SW'(DEPTH);
    end else begin
      size_act = SW'(size_reg_q);
    end
  end

  qpht_front #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .size_i       (size_act),
    .en_i         (init_done),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .op_i         (s_axis_tdata_i[1:0]),
    .key_i        (s_axis_tdata_i[KEY_BITS+1:2]),
    .push_valid_o (f_valid),
    .push_ready_i (f_ready),
    .push_cmd_o   (f_cmd),
    .push_key_o   (f_key),
    .push_home_o  (f_home)
  );

  qpht_queue #(.W(QW)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_home, f_key, f_cmd}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  assign q_cmd  = qpht_pkg::cmd_e'(q_data[1:0]);
  assign q_key  = q_data[KEY_BITS+1:2];
  assign q_home = q_data[QW-1:KEY_BITS+2];

  qpht_back #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .size_i       (size_act),
    .init_done_o  (init_done),
    .pop_valid_i  (q_valid),
    .pop_ready_o  (q_ready),
    .pop_cmd_i    (q_cmd),
    .pop_key_i    (q_key),
    .pop_home_i   (q_home),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (r_status),
    .out_slot_o   (r_slot)
  );

  assign m_axis_tdata_o = {3'b000, r_slot, r_status};

endmodule

@@ hw/rtl/qpht_front.sv @@
// Front end: accepts requests, decodes the op and computes the home slot.
module qpht_front #(
  parameter int unsigned DEPTH    = 1024,
  parameter int unsigned KEY_BITS = 31,
  parameter int unsigned AW       = $clog2(DEPTH),
  parameter int unsigned SW       = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [SW-1:0]        size_i,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           op_i,
  input  logic [KEY_BITS-1:0]  key_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output qpht_pkg::cmd_e       push_cmd_o,
  output logic [KEY_BITS-1:0]  push_key_o,
  output logic [AW-1:0]        push_home_o
);

  localparam int unsigned CW = $clog2(KEY_BITS + 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e state_q, state_d;
  qpht_pkg::cmd_e cmd_q, cmd_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [KEY_BITS-1:0] shf_q, shf_d;
  logic [SW-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW:0] rem_sh;

  assign in_ready_o   = (state_q == F_IDLE) && en_i;
  assign push_valid_o = (state_q == F_PUSH);
  assign push_cmd_o   = cmd_q;
  assign push_key_o   = key_q;
  assign push_home_o  = AW'(rem_q);

  // One restoring remainder step per cycle, key bits taken from the top.
  always_comb begin
    rem_sh = {rem_q, shf_q[KEY_BITS-1]};
    if (rem_sh >= {1'b0, size_i}) begin
      rem_sh = rem_sh - {1'b0, size_i};
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    key_d   = key_q;
    shf_d   = shf_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i && en_i) begin
          priority if (op_i == qpht_pkg::OP_INSERT) begin
            cmd_d = qpht_pkg::CMD_INSERT;
          end else if (op_i == qpht_pkg::OP_REMOVE) begin
            cmd_d = qpht_pkg::CMD_REMOVE;
          end else begin
            cmd_d = qpht_pkg::CMD_SEARCH;
          end
          key_d   = key_i;
          shf_d   = key_i;
          rem_d   = '0;
          cnt_d   = CW'(KEY_BITS);
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        rem_d = SW'(rem_sh);
        shf_d = shf_q << 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    key_q <= key_d;
    shf_q <= shf_d;
    rem_q <= rem_d;
  end

endmodule

@@ hw/rtl/qpht_queue.sv @@
// Two-entry queue between the front end and the probe engine.
module qpht_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] buf_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;
  logic do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = buf_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wr_q] <= push_data_i;
  end

endmodule

@@ hw/rtl/qpht_back.sv @@
// Probe engine: walks the quadratic probe sequence over the slot memory.
module qpht_back #(
  parameter int unsigned DEPTH    = 1024,
  parameter int unsigned KEY_BITS = 31,
  parameter int unsigned AW       = $clog2(DEPTH),
  parameter int unsigned SW       = $clog2(DEPTH + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [SW-1:0]                    size_i,
  output logic                             init_done_o,
  input  logic                             pop_valid_i,
  output logic                             pop_ready_o,
  input  qpht_pkg::cmd_e                   pop_cmd_i,
  input  logic [KEY_BITS-1:0]              pop_key_i,
  input  logic [AW-1:0]                    pop_home_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output qpht_pkg::status_e                out_status_o,
  output logic [qpht_pkg::SLOT_W-1:0]      out_slot_o
);

  localparam int unsigned EW = SW + 1;

  typedef enum logic [3:0] {
    B_CLEAR = 4'b0001,
    B_IDLE  = 4'b0010,
    B_READ  = 4'b0100,
    B_CHECK = 4'b1000
  } bstate_e;

  bstate_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] s_q, s_d;
  logic [AW-1:0] d_q, d_d;
  logic [SW-1:0] i_q, i_d;
  qpht_pkg::cmd_e cmd_q, cmd_d;
  logic [KEY_BITS-1:0] key_q, key_d;

  logic out_valid_q, out_valid_d;
  qpht_pkg::status_e status_q, status_d;
  logic [qpht_pkg::SLOT_W-1:0] slot_q, slot_d;

  // Each word holds the occupied flag above the stored key.
  logic [KEY_BITS:0] mem [DEPTH];
  logic [KEY_BITS:0] rdata_q;
  logic we;
  logic [AW-1:0] waddr;
  logic [KEY_BITS:0] wdata;

  logic [EW-1:0] sum_e, dn_e;
  logic occ, hit, last;
  logic do_pop;

  assign init_done_o  = (state_q != B_CLEAR);
  assign pop_ready_o  = (state_q == B_IDLE) && !out_valid_q;
  assign do_pop       = pop_valid_i && pop_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;
  assign out_slot_o   = slot_q;

  assign occ  = rdata_q[KEY_BITS];
  assign hit  = occ && (rdata_q[KEY_BITS-1:0] == key_q);
  assign last = (EW'(i_q) + EW'(1)) == EW'(size_i);

  // Next probe slot and next step, both kept below the table size.
  always_comb begin
    sum_e = EW'(s_q) + EW'(d_q);
    if (sum_e >= EW'(size_i)) sum_e = sum_e - EW'(size_i);
    dn_e = EW'(d_q) + EW'(2);
    if (dn_e >= EW'(size_i)) dn_e = dn_e - EW'(size_i);
    if (dn_e >= EW'(size_i)) dn_e = dn_e - EW'(size_i);
  end

  // Sequencer: clearing pass after reset, then one request at a time.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    s_d         = s_q;
    d_d         = d_q;
    i_d         = i_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    slot_d      = slot_q;
    we          = 1'b0;
    waddr       = s_q;
    wdata       = {1'b0, key_q};
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (do_pop) begin
          s_d     = pop_home_i;
          d_d     = (size_i == SW'(1)) ? '0 : AW'(1);
          i_d     = '0;
          cmd_d   = pop_cmd_i;
          key_d   = pop_key_i;
          state_d = B_READ;
        end
      end
      B_READ: begin
        state_d = B_CHECK;
      end
      B_CHECK: begin
        if (cmd_q == qpht_pkg::CMD_INSERT) begin
          if (!occ) begin
            we          = 1'b1;
            wdata       = {1'b1, key_q};
            status_d    = qpht_pkg::ST_INSERTED;
            slot_d      = qpht_pkg::SLOT_W'(s_q);
            out_valid_d = 1'b1;
            state_d     = B_IDLE;
          end else if (last) begin
            status_d    = qpht_pkg::ST_FULL;
            slot_d      = '0;
            out_valid_d = 1'b1;
            state_d     = B_IDLE;
          end else begin
            s_d     = AW'(sum_e);
            d_d     = AW'(dn_e);
            i_d     = i_q + 1'b1;
            state_d = B_READ;
          end
        end else begin
          if (hit) begin
            if (cmd_q == qpht_pkg::CMD_REMOVE) begin
              we       = 1'b1;
              wdata    = {1'b0, key_q};
              status_d = qpht_pkg::ST_REMOVED;
            end else begin
              status_d = qpht_pkg::ST_FOUND;
            end
            slot_d      = qpht_pkg::SLOT_W'(s_q);
            out_valid_d = 1'b1;
            state_d     = B_IDLE;
          end else if (!occ || last) begin
            status_d    = qpht_pkg::ST_NOT_FOUND;
            slot_d      = '0;
            out_valid_d = 1'b1;
            state_d     = B_IDLE;
          end else begin
            s_d     = AW'(sum_e);
            d_d     = AW'(dn_e);
            i_d     = i_q + 1'b1;
            state_d = B_READ;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q      <= s_d;
    d_q      <= d_d;
    i_q      <= i_d;
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    status_q <= status_d;
    slot_q   <= slot_d;
  end

  // Slot memory with one write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[s_q];
  end

  // No request is taken while the clearing pass runs.
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CLEAR) |-> !do_pop)
    else $error("request taken during clearing pass");

  // The probe count never reaches the table size.
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CHECK) |-> (EW'(i_q) < EW'(size_i)))
    else $error("probe count out of range");

  // A result only appears after a memory check.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == B_CHECK))
    else $error("result produced outside of a check");

  // The probe slot stays inside the active table.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CHECK) |-> (EW'(s_q) < EW'(size_i)))
    else $error("probe slot beyond table size");

endmodule
